// File: src/skat_pkg.sv
// skat_pkg: widths, constants, shared types and the saturation helper for the
// sorted key accumulate table; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package skat_pkg;

   localparam int HOSTS      = 4;
   localparam int COUNT_BITS = 8;
   localparam int ENTRIES    = 64;

   localparam int KEY_W = 32;
   localparam int LEN_W = 32;
   localparam int SUM_W = 48;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // only the low HOSTS*COUNT_BITS bits of a key take part
   localparam int KEY_USED = (HOSTS * COUNT_BITS >= KEY_W) ? KEY_W : HOSTS * COUNT_BITS;
   localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'(1) << KEY_USED) - 64'(1));

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic {
      OP_ACCUM  = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   // what a cell shows its right-hand neighbor
   typedef struct packed {
      logic                    gt;   // holds a live key above the probe
      logic                    lt;   // holds a live key below the probe
      logic [KEY_W-1:0]        key;
      logic signed [SUM_W-1:0] sum;
   } link_type;

   // commit command broadcast to every cell
   typedef struct packed {
      logic                    write_hit;
      logic                    insert;
      logic [KEY_W-1:0]        key;
      logic signed [SUM_W-1:0] sum;
   } cmd_type;

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W+1:0] v);
      logic signed [SUM_W+1:0] hi;
      logic signed [SUM_W+1:0] lo;
      hi = SUM_MAX;
      lo = SUM_MIN;
      if (v > hi) begin
         return SUM_MAX;
      end else if (v < lo) begin
         return SUM_MIN;
      end else begin
         return v[SUM_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: src/skat_if.sv
// skat_req_if and skat_rsp_if: valid/ready channels of the accumulate table
// depends on skat_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface skat_req_if import skat_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic [KEY_W-1:0]        key;
   logic signed [LEN_W-1:0] length;

   modport source (output valid, operation, key, length, input ready);
   modport sink   (input valid, operation, key, length, output ready);
endinterface

interface skat_rsp_if import skat_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic signed [SUM_W-1:0] value;
   logic signed [SUM_W-1:0] total;
   logic                    table_full;

   modport source (output valid, found, value, total, table_full, input ready);
   modport sink   (input valid, found, value, total, table_full, output ready);
endinterface

`default_nettype wire

// File: src/skat_cell.sv
// skat_cell: one slot of the sorted table with its compare flags and shift path
// depends on skat_pkg
`timescale 1ns / 1ps
`default_nettype none

module skat_cell import skat_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    cmp_en,
   input  wire logic                    in_use,
   input  wire logic [KEY_W-1:0]        probe_key,
   input  wire cmd_type                 cmd,
   input  wire link_type                left,
   output link_type                     right,
   output logic                         match,
   output logic signed [SUM_W-1:0]      hit_sum
);

   logic [KEY_W-1:0]        key_ff, key_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SUM_W-1:0] hit_ff, hit_in;
   logic                    lt_ff, lt_in;
   logic                    eq_ff, eq_in;

   always_comb begin
      key_in = key_ff;
      sum_in = sum_ff;
      hit_in = hit_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      if (cmp_en) begin
         lt_in  = in_use && (key_ff < probe_key);
         eq_in  = in_use && (key_ff == probe_key);
         hit_in = (in_use && (key_ff == probe_key)) ? sum_ff : '0;
      end
      if (cmd.insert) begin
         if (left.gt) begin
            // make room: take the neighbor's entry
            key_in = left.key;
            sum_in = left.sum;
         end else if (left.lt && !lt_ff) begin
            key_in = cmd.key;
            sum_in = cmd.sum;
         end
      end
      if (cmd.write_hit && eq_ff) begin
         sum_in = cmd.sum;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      sum_ff <= sum_in;
      hit_ff <= hit_in;
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

   assign right.gt  = in_use && !lt_ff && !eq_ff;
   assign right.lt  = lt_ff;
   assign right.key = key_ff;
   assign right.sum = sum_ff;
   assign match     = eq_ff;
   assign hit_sum   = hit_ff;

endmodule

`default_nettype wire

// File: src/sorted_key_accumulate_table_core.sv
// sorted_key_accumulate_table_core: top level, sequencer, gather and sum path
// depends on skat_pkg, skat_if (skat_req_if, skat_rsp_if) and skat_cell
`timescale 1ns / 1ps
`default_nettype none

// Sorted key accumulate table. Up to ENTRIES distinct keys are held in a row
// of cells in ascending unsigned order, live cells packed from cell 0, each
// with a signed Q32.16 sum. An accumulate beat (operation 0) adds its signed
// Q16.16 length to the matching key's sum, or inserts the key at its sorted
// place by shifting every larger entry one cell to the right. A lookup beat
// (operation 1) reads the key's sum and changes nothing. Every request gives
// one response beat with found, the key's sum after the beat (0 when absent
// or dropped), the running total of all sums and table_full, which flags an
// insert dropped because all ENTRIES cells are live. Sums and the total
// saturate to the signed 48-bit range. Key bits above HOSTS*COUNT_BITS are
// ignored. A beat runs through registered steps: all cells compare in
// parallel, the one matching sum is gathered, then add with saturation, the
// applied change, and the commit with the total. A new request is taken only
// after the previous beat has committed. A finished response sits in an
// output register, so a new request is taken while it still waits; the
// commit waits only when the previous response has not been taken yet.

module sorted_key_accumulate_table_core import skat_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   skat_req_if.sink     req_if,
   skat_rsp_if.source   rsp_if
);

   // one-hot sequencer states
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,  // waiting for a request beat
      ST_CMP  = 6'b000010,  // cells compare against the probe key
      ST_GATH = 6'b000100,  // gather found flag and matching sum
      ST_SUM  = 6'b001000,  // saturating add of the length
      ST_DIFF = 6'b010000,  // change actually applied to the entry
      ST_DONE = 6'b100000   // commit to cells, total and response
   } state_type;

   state_type state_ff, state_in;

   // request held for the whole beat
   op_type                  op_ff;
   logic [KEY_W-1:0]        key_ff;
   logic signed [LEN_W-1:0] len_ff;

   // sum path
   logic                    found_ff, found_in;
   logic signed [SUM_W-1:0] old_ff, old_in;
   logic signed [SUM_W-1:0] nv_ff, nv_in;
   logic signed [SUM_W:0]   delta_ff, delta_in;
   logic signed [SUM_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic signed [SUM_W-1:0] rsp_value_ff, rsp_value_in;
   logic signed [SUM_W-1:0] rsp_total_ff, rsp_total_in;
   logic                    rsp_full_ff, rsp_full_in;

   // cell row
   link_type                links [0:ENTRIES];
   logic [ENTRIES-1:0]      in_use;
   logic [ENTRIES-1:0]      eq_vec;
   logic [ENTRIES-1:0]      lt_vec;
   logic signed [SUM_W-1:0] hit_vec [ENTRIES];
   cmd_type                 cmd;

   logic                    accept;
   logic                    commit;
   logic                    table_is_full;
   logic                    any_eq;
   logic signed [SUM_W-1:0] hit_or;
   logic signed [SUM_W:0]   raw_sum;
   logic signed [SUM_W+1:0] total_raw;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign commit        = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign table_is_full = (count_ff == CNT_W'(ENTRIES));

   // live cells form a prefix of the row
   assign links[0] = '{gt: 1'b0, lt: 1'b1, key: '0, sum: '0};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      assign in_use[i] = (CNT_W'(i) < count_ff);
      assign lt_vec[i] = links[i+1].lt;

      skat_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmp_en    (state_ff == ST_CMP),
         .in_use    (in_use[i]),
         .probe_key (key_ff),
         .cmd       (cmd),
         .left      (links[i]),
         .right     (links[i+1]),
         .match     (eq_vec[i]),
         .hit_sum   (hit_vec[i])
      );
   end

   // at most one cell matches, so an or of the masked sums selects it
   always_comb begin
      hit_or = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_or = hit_or | hit_vec[i];
      end
   end
   assign any_eq = |eq_vec;

   assign raw_sum   = (SUM_W+1)'(old_ff) + (SUM_W+1)'(len_ff);
   assign total_raw = (SUM_W+2)'(total_ff) + (SUM_W+2)'(delta_ff);

   // commit command: write the hit cell, or shift and insert
   always_comb begin
      cmd.write_hit = commit && (op_ff == OP_ACCUM) && found_ff;
      cmd.insert    = commit && (op_ff == OP_ACCUM) && !found_ff && !table_is_full;
      cmd.key       = key_ff;
      cmd.sum       = nv_ff;
   end

   always_comb begin
      state_in     = state_ff;
      found_in     = found_ff;
      old_in       = old_ff;
      nv_in        = nv_ff;
      delta_in     = delta_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      rsp_total_in = rsp_total_ff;
      rsp_full_in  = rsp_full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_GATH;
         end
         ST_GATH: begin
            found_in = any_eq;
            old_in   = hit_or;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            nv_in    = sat_sum((SUM_W+2)'(raw_sum));
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            delta_in = (SUM_W+1)'(nv_ff) - (SUM_W+1)'(old_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_full_in  = 1'b0;
               rsp_total_in = total_ff;
               if (op_ff == OP_LOOKUP) begin
                  rsp_value_in = old_ff;
               end else if (found_ff || !table_is_full) begin
                  // hit or insert: same saturating total update
                  total_in     = sat_sum(total_raw);
                  rsp_total_in = sat_sum(total_raw);
                  rsp_value_in = nv_ff;
                  if (!found_ff) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  rsp_value_in = '0;
                  rsp_full_in  = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_if.operation);
         key_ff <= req_if.key & KEY_MASK;
         len_ff <= req_if.length;
      end
      found_ff     <= found_in;
      old_ff       <= old_in;
      nv_ff        <= nv_in;
      delta_ff     <= delta_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_total_ff <= rsp_total_in;
      rsp_full_ff  <= rsp_full_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.found      = rsp_found_ff;
   assign rsp_if.value      = rsp_value_ff;
   assign rsp_if.total      = rsp_total_ff;
   assign rsp_if.table_full = rsp_full_ff;

`ifndef ASSERT_OFF
   // keys are distinct, so a probe never matches two cells
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GATH) |-> $onehot0(eq_vec))
      else $error("more than one cell matched the probe key");

   // the row stays sorted: cells below the probe form a prefix
   a_sorted_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GATH) |-> ((lt_vec & (lt_vec + ENTRIES'(1))) == '0))
      else $error("cells below the probe key are not a prefix of the row");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count beyond table size");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not add one entry");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && rsp_found_ff))
      else $error("dropped insert reported as found");
`endif

endmodule

`default_nettype wire

// File: tb/tb_sorted_key_accumulate_table_core.sv
// tb_sorted_key_accumulate_table_core: self-checking bench for the sorted key accumulate table
// depends on skat_pkg, skat_req_if / skat_rsp_if and sorted_key_accumulate_table_core
// directed corners, then bursty random traffic against a tracked table
`timescale 1ns / 1ps

module tb_sorted_key_accumulate_table_core;
   import skat_pkg::*;

   localparam int RANDOM_BEATS = 1300;
   // the receiver holds off once, well inside the random traffic
   localparam int HOLD_AT      = 420;
   localparam int HOLD_CYCLES  = 400;

   localparam longint SUM_CEIL  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_FLOOR = -SUM_CEIL - 1;

   // receiver back-pressure patterns
   typedef enum int {
      RX_OPEN,
      RX_MOSTLY,
      RX_EVERY_FOURTH,
      RX_SPARSE
   } rx_pattern;

   typedef struct {
      logic                    found;
      logic signed [SUM_W-1:0] value;
      logic signed [SUM_W-1:0] total;
      logic                    table_full;
   } rsp_fields;

   // tracks the sorted table, owes one response per accepted request beat
   class sum_table_tracker;
      logic [KEY_W-1:0]        keys [ENTRIES];
      logic signed [SUM_W-1:0] sums [ENTRIES];
      int                      live;
      longint                  total;
      rsp_fields               owed_q [$];
      int                      errors;
      int                      inserts;
      int                      updates;
      int                      lookups;
      int                      drops;
      int                      clamps;

      static function longint clamp(longint v);
         if (v > SUM_CEIL) return SUM_CEIL;
         if (v < SUM_FLOOR) return SUM_FLOOR;
         return v;
      endfunction

      function int owed();
         return owed_q.size();
      endfunction

      function logic [KEY_W-1:0] key_at(int idx);
         return keys[idx];
      endfunction

      function void take_request(op_type op, logic [KEY_W-1:0] raw_key,
                                 logic signed [LEN_W-1:0] length);
         rsp_fields        want;
         logic [KEY_W-1:0] k;
         int               slot;
         longint           prev;
         longint           next;
         k = raw_key & KEY_MASK;
         slot = 0;
         while (slot < live && keys[slot] < k) slot++;
         want.found      = (slot < live) && (keys[slot] == k);
         want.value      = '0;
         want.table_full = 1'b0;
         if (op == OP_LOOKUP) begin
            lookups++;
            if (want.found) want.value = sums[slot];
         end else if (want.found) begin
            prev = sums[slot];
            next = clamp(prev + longint'(length));
            if (next != prev + longint'(length)) clamps++;
            sums[slot] = next[SUM_W-1:0];
            total = clamp(total + (next - prev));
            want.value = sums[slot];
            updates++;
         end else if (live >= ENTRIES) begin
            want.table_full = 1'b1;
            drops++;
         end else begin
            for (int i = live; i > slot; i--) begin
               keys[i] = keys[i-1];
               sums[i] = sums[i-1];
            end
            keys[slot] = k;
            sums[slot] = length;
            live++;
            total = clamp(total + longint'(length));
            want.value = sums[slot];
            inserts++;
         end
         want.total = total[SUM_W-1:0];
         owed_q.push_back(want);
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_fields got);
         rsp_fields want;
         if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing owed, actual found %0d value %0d total %0d",
                     $time, got.found, got.value, got.total);
            return;
         end
         want = owed_q.pop_front();
         compare_field("found", want.found, got.found);
         compare_field("value", want.value, got.value);
         compare_field("total", want.total, got.total);
         compare_field("table_full", want.table_full, got.table_full);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   rsp_beats = 0;

   sum_table_tracker board = new;

   skat_req_if req_ch ();
   skat_rsp_if rsp_ch ();

   sorted_key_accumulate_table_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // offer one request beat and hold it until the block takes it; valid stays high
   // on return so back-to-back beats never drop it
   task automatic send_beat(op_type op, logic [KEY_W-1:0] key,
                            logic signed [LEN_W-1:0] length);
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.key       <= key;
      req_ch.length    <= length;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.take_request(op, key, length);
   endtask

   // request side: reset, directed corners, random bursts, drain
   initial begin : req_side
      int                      pick;
      int                      gap;
      int                      burst_left;
      logic [KEY_W-1:0]        key;
      logic signed [LEN_W-1:0] length;
      op_type                  op;

      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_ACCUM;
      req_ch.key       <= '0;
      req_ch.length    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // lookup on an empty table misses
      send_beat(OP_LOOKUP, 32'h0000_0000, 32'sh0000_0000);
      // zero-length accumulate still inserts, lowest key
      send_beat(OP_ACCUM, 32'h0000_0000, 32'sh0000_0000);
      // highest key with the largest positive length
      send_beat(OP_ACCUM, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
      // most negative length lands between the ends
      send_beat(OP_ACCUM, 32'h8000_0000, 32'sh8000_0000);
      // lookup hit, its length must be ignored
      send_beat(OP_LOOKUP, 32'h8000_0000, 32'sh7FFF_FFFF);
      // lookup miss one below a live key
      send_beat(OP_LOOKUP, 32'h7FFF_FFFF, 32'sh0000_0001);
      // inserts right above and right below a live key
      send_beat(OP_ACCUM, 32'h8000_0001, 32'sh0000_0001);
      send_beat(OP_ACCUM, 32'h7FFF_FFFF, 32'shFFFF_FFFF);
      // updates at the bottom, the top and the middle
      send_beat(OP_ACCUM, 32'h0000_0000, 32'sh0001_0000);
      send_beat(OP_ACCUM, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
      send_beat(OP_ACCUM, 32'h8000_0000, 32'sh7FFF_FFFF);
      // inserts near the bottom and alternating bit patterns
      send_beat(OP_ACCUM, 32'h0000_0001, 32'sh8000_0000);
      send_beat(OP_ACCUM, 32'h0102_0304, 32'sh0001_8000);
      send_beat(OP_ACCUM, 32'hAAAA_AAAA, 32'sh5555_5555);
      send_beat(OP_ACCUM, 32'h5555_5555, 32'shAAAA_AAAA);
      // pull the running total negative
      send_beat(OP_ACCUM, 32'h00FF_00FF, 32'sh8000_0000);
      send_beat(OP_ACCUM, 32'hFF00_FF00, 32'sh8000_0000);
      send_beat(OP_ACCUM, 32'h7F7F_7F7F, 32'sh8000_0000);
      send_beat(OP_LOOKUP, 32'h5555_5555, 32'sh1234_5678);
      send_beat(OP_LOOKUP, 32'h0000_0002, 32'sh0000_0000);

      // random traffic in bursts; the table fills early, later new keys get dropped
      burst_left = 0;
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;

         op = ($urandom_range(0, 3) == 0) ? OP_LOOKUP : OP_ACCUM;

         // mostly live keys, some neighbors of live keys, the rest fresh
         pick = $urandom_range(0, 99);
         if (board.live > 0 && pick < 55) begin
            key = board.key_at($urandom_range(0, board.live - 1));
         end else if (board.live > 0 && pick < 65) begin
            key = board.key_at($urandom_range(0, board.live - 1));
            key = $urandom_range(0, 1) ? key + 32'd1 : key - 32'd1;
         end else if (pick < 70) begin
            key = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
         end else begin
            key = $urandom();
         end

         // full-range, small signed and extreme lengths
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            length = $urandom();
         end else if (pick < 75) begin
            length = $urandom_range(0, 32'h0003_FFFF);
            if ($urandom_range(0, 1)) length = -length;
         end else begin
            case ($urandom_range(0, 4))
               0:       length = 32'sh7FFF_FFFF;
               1:       length = 32'sh8000_0000;
               2:       length = 32'sh0000_0000;
               3:       length = 32'sh0000_0001;
               default: length = 32'shFFFF_FFFF;
            endcase
         end

         send_beat(op, key, length);
      end
      req_ch.valid <= 1'b0;

      // wait out every owed response, then a quiet stretch to catch strays
      while (board.owed() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d request beats: %0d inserts, %0d updates (%0d clipped), %0d lookups",
               board.inserts + board.updates + board.lookups + board.drops,
               board.inserts, board.updates, board.clamps, board.lookups);
      $display("%0d inserts dropped on a full table, %0d of %0d entries live at the end",
               board.drops, board.live, ENTRIES);
      if (board.errors == 0 && board.owed() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // response side: check each beat, ready follows a pattern that changes now and then,
   // plus one long hold-off so the block backs up into its request port
   initial begin : rsp_side
      rsp_fields got;
      rx_pattern stall_mode;
      int        mode_left;
      int        hold_left;
      int        phase;

      rsp_ch.ready <= 1'b0;
      stall_mode = RX_OPEN;
      mode_left  = 0;
      hold_left  = 0;
      phase      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.found      = rsp_ch.found;
            got.value      = rsp_ch.value;
            got.total      = rsp_ch.total;
            got.table_full = rsp_ch.table_full;
            board.check_response(got);
            rsp_beats++;
            if (rsp_beats == HOLD_AT) hold_left = HOLD_CYCLES;
         end

         // pick a new pattern after a random stretch
         if (mode_left == 0) begin
            stall_mode = rx_pattern'($urandom_range(0, 3));
            mode_left  = $urandom_range(32, 300);
         end else begin
            mode_left--;
         end
         phase++;

         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (stall_mode)
               RX_OPEN:         rsp_ch.ready <= 1'b1;
               RX_MOSTLY:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               RX_EVERY_FOURTH: rsp_ch.ready <= (phase % 4 != 0);
               default:         rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2ms;
      $display("timeout with %0d responses still owed", board.owed());
      $display("Some tests failed");
      $finish;
   end

endmodule
